@@ src/stkt_pkg.sv @@
// stkt_pkg: shared types and constants for the streaming top-k threshold block
// used by stkt_ctrl, stkt_dpath, stkt_checker and streaming_top_k_threshold; no dependencies
package stkt_pkg;

  // width of the top_count register and of the held count
  localparam int CNT_W = 5;
  // width of the saturating replacement counter
  localparam int TOTAL_W = 16;
  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  // register index, taken from paddr[2]
  localparam logic REG_TOP_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] TOP_COUNT_RESET = 5'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the accepted sample
    logic insert;   // trim, compare and shift the sorted chain
    logic publish;  // move the finished result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic result_full;  // output register holds a result not yet taken
    logic result_take;  // output register is being taken this cycle
  } status_t;

endpackage

@@ src/streaming_top_k_threshold.sv @@
// streaming_top_k_threshold: keeps the largest top_count samples seen and
// reports the smallest kept one; uses stkt_pkg, stkt_ctrl and stkt_dpath
//
//   channel   handshake                    payload
//   sample    sample_valid / sample_ready  sample
//   result    result_valid / result_ready  threshold, held_count, replaced,
//                                          replacement_total
//   config    apb psel/penable/pwrite      paddr, pwdata, prdata (top_count)
//
// each request goes through capture, one parallel compare-and-shift
// of the sorted chain, then load of the output register
// the next request is taken while a result still waits in the output register;
// a finished result waits in the controller until that register frees up
// rst is synchronous: the chain is emptied by clearing the held count, the
// replacement counter goes to zero and top_count returns to 3
// top_count is meant to change only between requests; zero acts as one
module streaming_top_k_threshold #(
  parameter int MAX_KEEP    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  // result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [SAMPLE_BITS-1:0]       threshold,
  output logic [stkt_pkg::CNT_W-1:0]          held_count,
  output logic                                replaced,
  output logic [stkt_pkg::TOTAL_W-1:0]        replacement_total,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stkt_pkg::ADDR_W-1:0]         paddr,
  input  logic [stkt_pkg::DATA_W-1:0]         pwdata,
  output logic [stkt_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  stkt_pkg::cmd_t    cmd;
  stkt_pkg::status_t status;

  logic [stkt_pkg::CNT_W-1:0] top_count;
  logic                       reg_sel;

  // register index from the word address
  assign reg_sel = (paddr[2] == stkt_pkg::REG_TOP_COUNT);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= stkt_pkg::TOP_COUNT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      top_count <= pwdata[stkt_pkg::CNT_W-1:0];
    end
  end

  // unmapped addresses read as zero
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(stkt_pkg::DATA_W - stkt_pkg::CNT_W){1'b0}}, top_count};
    end
  end

  stkt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  stkt_dpath #(
    .MAX_KEEP    (MAX_KEEP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .top_count         (top_count),
    .sample            (sample),
    .result_ready      (result_ready),
    .result_valid      (result_valid),
    .threshold         (threshold),
    .held_count        (held_count),
    .replaced          (replaced),
    .replacement_total (replacement_total)
  );

endmodule

@@ src/stkt_ctrl.sv @@
// stkt_ctrl: request sequencer, idle -> insert -> result
// depends on stkt_pkg (state_t, cmd_t, status_t)
module stkt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  stkt_pkg::status_t status,
  output stkt_pkg::cmd_t   cmd
);

  stkt_pkg::state_t state;
  stkt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stkt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    cmd          = '0;
    case (state)
      stkt_pkg::S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = stkt_pkg::S_INSERT;
        end
      end
      stkt_pkg::S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = stkt_pkg::S_RESULT;
      end
      stkt_pkg::S_RESULT: begin
        // wait for the output register to free up
        if (!status.result_full || status.result_take) begin
          cmd.publish = 1'b1;
          state_next  = stkt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = stkt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/stkt_dpath.sv @@
// stkt_dpath: sorted register chain with parallel compare-and-shift insert,
// counters and output register; depends on stkt_pkg (cmd_t, status_t, widths)
module stkt_dpath #(
  parameter int MAX_KEEP    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  stkt_pkg::cmd_t                  cmd,
  output stkt_pkg::status_t               status,
  input  logic [stkt_pkg::CNT_W-1:0]      top_count,
  input  logic signed [SAMPLE_BITS-1:0]   sample,
  input  logic                            result_ready,
  output logic                            result_valid,
  output logic signed [SAMPLE_BITS-1:0]   threshold,
  output logic [stkt_pkg::CNT_W-1:0]      held_count,
  output logic                            replaced,
  output logic [stkt_pkg::TOTAL_W-1:0]    replacement_total
);

  localparam int CW = stkt_pkg::CNT_W;
  localparam int TW = stkt_pkg::TOTAL_W;
  // largest usable k: limited by the chain depth and the register width
  localparam int KCAP = (MAX_KEEP < (2**CW - 1)) ? MAX_KEEP : (2**CW - 1);

  logic signed [SAMPLE_BITS-1:0] key;
  logic signed [SAMPLE_BITS-1:0] chain [MAX_KEEP];
  logic signed [SAMPLE_BITS-1:0] chain_next [MAX_KEEP];
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;
  logic [TW-1:0]                 total;
  logic [TW-1:0]                 total_next;
  logic                          rep_flag;

  logic [CW-1:0]       k_eff;
  logic [CW-1:0]       cnt_trim;
  logic [CW-1:0]       keep_n;
  logic                full;
  logic                evict;
  logic                write_en;
  logic [MAX_KEEP-1:0] ge;
  logic [MAX_KEEP-1:0] stay;
  logic signed [SAMPLE_BITS-1:0] thr_mux;

  always_comb begin
    // zero means one, large values clip to the chain depth
    if (top_count == '0) begin
      k_eff = CW'(1);
    end else if (int'(top_count) > KCAP) begin
      k_eff = CW'(KCAP);
    end else begin
      k_eff = top_count;
    end
    // a lowered k drops the smallest entries first
    cnt_trim = (count > k_eff) ? k_eff : count;
    full     = (cnt_trim == k_eff);
    keep_n   = full ? (cnt_trim - CW'(1)) : cnt_trim;

    // ge is a prefix since the chain is sorted descending
    evict = 1'b0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      ge[i] = (i < int'(cnt_trim)) && (chain[i] >= key);
      if ((i < int'(cnt_trim)) && !ge[i]) begin
        evict = 1'b1;
      end
      stay[i] = ge[i] && (i < int'(keep_n));
    end
    evict    = evict && full;
    write_en = !full || evict;

    // equal values stay ahead of the new one
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (stay[i]) begin
        chain_next[i] = chain[i];
      end else if (i == 0) begin
        chain_next[i] = key;
      end else if (stay[i-1]) begin
        chain_next[i] = key;
      end else begin
        chain_next[i] = chain[i-1];
      end
    end

    count_next = full ? cnt_trim : (cnt_trim + CW'(1));
    total_next = (evict && (total != {TW{1'b1}})) ? (total + TW'(1)) : total;

    // threshold is the last held entry
    thr_mux = chain[0];
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (i == int'(count) - 1) begin
        thr_mux = chain[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= sample;
    end
    if (cmd.insert && write_en) begin
      for (int i = 0; i < MAX_KEEP; i++) begin
        chain[i] <= chain_next[i];
      end
    end
    if (cmd.insert) begin
      rep_flag <= evict;
    end
    if (cmd.publish) begin
      threshold         <= thr_mux;
      held_count        <= count;
      replaced          <= rep_flag;
      replacement_total <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= count_next;
        total <= total_next;
      end
      if (cmd.publish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign status.result_full = result_valid;
  assign status.result_take = result_valid && result_ready;

endmodule

@@ src/stkt_checker.sv @@
// stkt_checker: port-level checks for streaming_top_k_threshold, with its bind
// depends on stkt_pkg for port widths
module stkt_checker #(
  parameter int MAX_KEEP    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             sample_valid,
  input logic                             sample_ready,
  input logic                             result_valid,
  input logic                             result_ready,
  input logic [stkt_pkg::CNT_W-1:0]       held_count,
  input logic                             replaced,
  input logic [stkt_pkg::TOTAL_W-1:0]     replacement_total
);

  // a waiting result is not dropped
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // one request at a time: busy right after a request is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("request taken while previous one in work");

  // every result holds at least one value
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> held_count != '0)
    else $error("result with empty store");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> int'(held_count) <= MAX_KEEP)
    else $error("held count beyond chain depth");

  // a replacement is always counted
  a_total_on_replace: assert property (@(posedge clk) disable iff (rst)
    result_valid && replaced |-> replacement_total != '0)
    else $error("replacement without count");

endmodule

bind streaming_top_k_threshold stkt_checker #(
  .MAX_KEEP    (MAX_KEEP),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_stkt_checker (
  .clk               (clk),
  .rst               (rst),
  .sample_valid      (sample_valid),
  .sample_ready      (sample_ready),
  .result_valid      (result_valid),
  .result_ready      (result_ready),
  .held_count        (held_count),
  .replaced          (replaced),
  .replacement_total (replacement_total)
);
